[src/pfc_pkg.sv]
// Shared types and constants for the page-fault clock replacement unit.
// No dependencies; used by page_fault_clock_replacer_unit.
`default_nettype none
package pfc_pkg;

    // Table sizes of this build.
    localparam int NumPages     = 256;
    localparam int NumFrames    = 64;
    localparam int NumProcesses = 4;
    localparam int MaxResident  = 16;

    localparam int PageW  = 8;
    localparam int FrameW = 6;
    localparam int PidW   = 2;
    localparam int SlotW  = 4;
    localparam int CountW = 5;
    localparam int QuotaW = 5;
    localparam int StepW  = 7;

    // Search bounds of the plain and modified clock variants, in ring steps.
    localparam logic [StepW-1:0] PLAIN_STEPS = 7'd34;
    localparam logic [StepW-1:0] MOD_STEPS   = 7'd68;

    // Configuration register indexes.
    localparam logic REG_FRAMES_PER_PROCESS = 1'b0;
    localparam logic REG_REPLACEMENT_MODE   = 1'b1;

    // Operation codes.
    localparam logic [2:0] OP_CREATE    = 3'd0;
    localparam logic [2:0] OP_TRANSLATE = 3'd1;
    localparam logic [2:0] OP_MARK_READ = 3'd2;
    localparam logic [2:0] OP_MARK_WRITE = 3'd3;
    localparam logic [2:0] OP_FAULT     = 3'd4;
    localparam logic [2:0] OP_RELEASE   = 3'd5;

    // One page table entry.
    typedef struct packed {
        logic [PidW-1:0]   owner;
        logic [FrameW-1:0] frame;
        logic              present;
        logic              use_bit;
        logic              modified;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_E,
        ST_DEC,
        ST_FREE_SCAN,
        ST_LOAD_WR,
        ST_POP,
        ST_POP_PG,
        ST_EVAL,
        ST_EVICT_V,
        ST_EVICT_E,
        ST_REL_RD,
        ST_REL_CK,
        ST_OUT_RD,
        ST_OUT
    } state_t;

endpackage
`default_nettype wire

[src/page_fault_clock_replacer_unit.sv]
// Page-fault handler with a page table, frame bitmap and per-process clock rings.
// Depends on pfc_pkg.
`default_nettype none
// A command is taken when start is high and busy is low; its single result
// beat appears for one cycle with done high and cannot be stalled. The page
// table and the rings live in synchronous memories, so every read is
// registered. A fault under quota scans the frame bitmap for a free frame,
// up to 64 frames. A replacement reads and evaluates one ring entry per look,
// up to about 35 looks for plain clock and about 140 for modified clock.
// Release walks all 256 page entries, reading and then checking each.
module page_fault_clock_replacer_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  operation,
    input  wire logic [7:0]  page,
    input  wire logic [1:0]  process_id,
    output logic             done,
    output logic             present,
    output logic [5:0]       frame,
    output logic             fault,
    output logic             load_request,
    output logic             victim_valid,
    output logic [7:0]       victim_page,
    output logic             writeback,
    output logic             error,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int PW = pfc_pkg::PageW;
    localparam int FW = pfc_pkg::FrameW;
    localparam int IW = pfc_pkg::PidW;
    localparam int SW = pfc_pkg::SlotW;
    localparam int CW = pfc_pkg::CountW;
    localparam int QW = pfc_pkg::QuotaW;
    localparam int TW = pfc_pkg::StepW;

    pfc_pkg::state_t state_reg, state_next;

    logic [2:0]    op_reg;
    logic [PW-1:0] pg_reg;
    logic [IW-1:0] pid_reg, p_reg, p_next;
    pfc_pkg::entry_t e_reg, e_next, ve_reg, ve_next;
    logic [PW-1:0] v_reg, v_next;
    logic [FW-1:0] f_reg, f_next;
    logic [PW-1:0] rel_reg, rel_next;
    logic [TW-1:0] step_reg, step_next, pass_reg, pass_next;
    logic          phase_reg, phase_next, last_reg, last_next;
    logic [QW-1:0] fpp_reg, q_val;
    logic          mode_reg;
    logic [pfc_pkg::NumFrames-1:0] busy_reg, busy_next;
    logic [SW-1:0] head_reg [pfc_pkg::NumProcesses];
    logic [SW-1:0] head_next [pfc_pkg::NumProcesses];
    logic [CW-1:0] count_reg [pfc_pkg::NumProcesses];
    logic [CW-1:0] count_next [pfc_pkg::NumProcesses];
    logic fault_reg, fault_next, load_reg, load_next, vv_reg, vv_next;
    logic wb_reg, wb_next, err_reg, err_next;

    // Page table memory with a valid bit per entry: unwritten entries read as zero.
    pfc_pkg::entry_t pmem [pfc_pkg::NumPages];
    logic [pfc_pkg::NumPages-1:0] pvalid_reg;
    pfc_pkg::entry_t pm_q, pm_rd, pm_wdata;
    logic          pv_q, pm_we;
    logic [PW-1:0] pm_raddr, pm_waddr;

    // Resident ring memory, one row of slots per process.
    logic [PW-1:0]    rmem [pfc_pkg::NumProcesses * pfc_pkg::MaxResident];
    logic [PW-1:0]    rm_q, rm_wdata;
    logic             rm_we;
    logic [IW+SW-1:0] rm_raddr, rm_waddr;

    logic cfg_wr;
    logic [SW-1:0] push_slot;

    // Page table storage.
    always_ff @(posedge clk)
    begin
        if (pm_we)
        begin
            pmem[pm_waddr] <= pm_wdata;
        end
        pm_q <= pmem[pm_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pvalid_reg <= '0;
            pv_q       <= 1'b0;
        end
        else
        begin
            pv_q <= pvalid_reg[pm_raddr];
            if (pm_we)
            begin
                pvalid_reg[pm_waddr] <= 1'b1;
            end
        end
    end

    assign pm_rd = pv_q ? pm_q : '0;

    // Ring storage.
    always_ff @(posedge clk)
    begin
        if (rm_we)
        begin
            rmem[rm_waddr] <= rm_wdata;
        end
        rm_q <= rmem[rm_raddr];
    end

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_comb
    begin
        if (paddr[2] == pfc_pkg::REG_REPLACEMENT_MODE)
        begin
            prdata = {31'd0, mode_reg};
        end
        else
        begin
            prdata = {{(32-QW){1'b0}}, fpp_reg};
        end
    end

    // Effective quota: zero acts as one, large values clamp to the ring size.
    always_comb
    begin
        if (fpp_reg == '0)
        begin
            q_val = QW'(1);
        end
        else if (fpp_reg > QW'(pfc_pkg::MaxResident))
        begin
            q_val = QW'(pfc_pkg::MaxResident);
        end
        else
        begin
            q_val = fpp_reg;
        end
    end

    assign busy      = (state_reg != pfc_pkg::ST_IDLE);
    assign push_slot = head_reg[p_reg] + count_reg[p_reg][SW-1:0];

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pfc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = pfc_pkg::ST_RD_E;
                end
            end
            pfc_pkg::ST_RD_E:
            begin
                state_next = pfc_pkg::ST_DEC;
            end
            pfc_pkg::ST_DEC:
            begin
                state_next = pfc_pkg::ST_OUT_RD;
                if (op_reg == pfc_pkg::OP_RELEASE)
                begin
                    state_next = pfc_pkg::ST_REL_RD;
                end
                else if (op_reg == pfc_pkg::OP_FAULT && !pm_rd.present)
                begin
                    if (count_reg[pm_rd.owner] < q_val)
                    begin
                        state_next = pfc_pkg::ST_FREE_SCAN;
                    end
                    else
                    begin
                        state_next = pfc_pkg::ST_POP;
                    end
                end
            end
            pfc_pkg::ST_FREE_SCAN:
            begin
                if (!busy_reg[f_reg])
                begin
                    state_next = pfc_pkg::ST_LOAD_WR;
                end
                else if (f_reg == FW'(pfc_pkg::NumFrames - 1))
                begin
                    state_next = pfc_pkg::ST_OUT_RD;
                end
            end
            pfc_pkg::ST_LOAD_WR:
            begin
                state_next = pfc_pkg::ST_OUT_RD;
            end
            pfc_pkg::ST_POP:
            begin
                state_next = pfc_pkg::ST_POP_PG;
            end
            pfc_pkg::ST_POP_PG:
            begin
                state_next = pfc_pkg::ST_EVAL;
            end
            pfc_pkg::ST_EVAL:
            begin
                state_next = pfc_pkg::ST_POP;
                if (last_reg)
                begin
                    state_next = pfc_pkg::ST_EVICT_V;
                end
                else if (!mode_reg || phase_reg)
                begin
                    if (!pm_rd.use_bit)
                    begin
                        state_next = pfc_pkg::ST_EVICT_V;
                    end
                end
                else if (!pm_rd.use_bit && !pm_rd.modified)
                begin
                    state_next = pfc_pkg::ST_EVICT_V;
                end
            end
            pfc_pkg::ST_EVICT_V:
            begin
                state_next = pfc_pkg::ST_EVICT_E;
            end
            pfc_pkg::ST_EVICT_E:
            begin
                state_next = pfc_pkg::ST_OUT_RD;
            end
            pfc_pkg::ST_REL_RD:
            begin
                state_next = pfc_pkg::ST_REL_CK;
            end
            pfc_pkg::ST_REL_CK:
            begin
                if (rel_reg == PW'(pfc_pkg::NumPages - 1))
                begin
                    state_next = pfc_pkg::ST_OUT_RD;
                end
                else
                begin
                    state_next = pfc_pkg::ST_REL_RD;
                end
            end
            pfc_pkg::ST_OUT_RD:
            begin
                state_next = pfc_pkg::ST_OUT;
            end
            pfc_pkg::ST_OUT:
            begin
                state_next = pfc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = pfc_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath: memory controls, ring pointers, bitmap and result flags.
    always_comb
    begin
        p_next     = p_reg;
        e_next     = e_reg;
        ve_next    = ve_reg;
        v_next     = v_reg;
        f_next     = f_reg;
        rel_next   = rel_reg;
        step_next  = step_reg;
        pass_next  = pass_reg;
        phase_next = phase_reg;
        last_next  = last_reg;
        busy_next  = busy_reg;
        head_next  = head_reg;
        count_next = count_reg;
        fault_next = fault_reg;
        load_next  = load_reg;
        vv_next    = vv_reg;
        wb_next    = wb_reg;
        err_next   = err_reg;
        pm_raddr   = pg_reg;
        pm_we      = 1'b0;
        pm_waddr   = pg_reg;
        pm_wdata   = e_reg;
        rm_raddr   = {p_reg, head_reg[p_reg]};
        rm_we      = 1'b0;
        rm_waddr   = {p_reg, push_slot};
        rm_wdata   = v_reg;
        case (state_reg)
            pfc_pkg::ST_IDLE:
            begin
                fault_next = 1'b0;
                load_next  = 1'b0;
                vv_next    = 1'b0;
                wb_next    = 1'b0;
                err_next   = 1'b0;
                v_next     = '0;
                pm_raddr   = page;
            end
            pfc_pkg::ST_DEC:
            begin
                e_next     = pm_rd;
                p_next     = pm_rd.owner;
                f_next     = '0;
                rel_next   = '0;
                step_next  = '0;
                pass_next  = '0;
                phase_next = 1'b0;
                last_next  = 1'b0;
                pm_wdata   = pm_rd;
                case (op_reg)
                    pfc_pkg::OP_CREATE:
                    begin
                        pm_we    = !pm_rd.present;
                        pm_wdata = '{owner: pid_reg, frame: '0, present: 1'b0,
                                     use_bit: 1'b0, modified: 1'b0};
                    end
                    pfc_pkg::OP_TRANSLATE:
                    begin
                        fault_next = !pm_rd.present;
                    end
                    pfc_pkg::OP_MARK_READ:
                    begin
                        pm_we            = pm_rd.present;
                        pm_wdata.use_bit = 1'b1;
                    end
                    pfc_pkg::OP_MARK_WRITE:
                    begin
                        pm_we             = pm_rd.present;
                        pm_wdata.use_bit  = 1'b1;
                        pm_wdata.modified = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            pfc_pkg::ST_FREE_SCAN:
            begin
                if (busy_reg[f_reg])
                begin
                    if (f_reg == FW'(pfc_pkg::NumFrames - 1))
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        f_next = f_reg + FW'(1);
                    end
                end
            end
            pfc_pkg::ST_LOAD_WR:
            begin
                busy_next[f_reg] = 1'b1;
                pm_we    = 1'b1;
                pm_wdata = '{owner: e_reg.owner, frame: f_reg, present: 1'b1,
                             use_bit: 1'b1, modified: 1'b0};
                rm_we    = 1'b1;
                rm_wdata = pg_reg;
                if (count_reg[p_reg] < CW'(pfc_pkg::MaxResident))
                begin
                    count_next[p_reg] = count_reg[p_reg] + CW'(1);
                end
                load_next = 1'b1;
            end
            pfc_pkg::ST_POP:
            begin
                head_next[p_reg] = head_reg[p_reg] + SW'(1);
                if (count_reg[p_reg] > '0)
                begin
                    count_next[p_reg] = count_reg[p_reg] - CW'(1);
                end
            end
            pfc_pkg::ST_POP_PG:
            begin
                v_next   = rm_q;
                pm_raddr = rm_q;
            end
            pfc_pkg::ST_EVAL:
            begin
                ve_next  = pm_rd;
                pm_waddr = v_reg;
                pm_wdata = pm_rd;
                pm_wdata.use_bit = 1'b0;
                if (!last_reg)
                begin
                    if (!mode_reg || phase_reg)
                    begin
                        // Second chance: clear use and requeue.
                        if (pm_rd.use_bit)
                        begin
                            pm_we      = 1'b1;
                            rm_we      = 1'b1;
                            phase_next = 1'b0;
                            step_next  = step_reg + TW'(1);
                            if (count_reg[p_reg] < CW'(pfc_pkg::MaxResident))
                            begin
                                count_next[p_reg] = count_reg[p_reg] + CW'(1);
                            end
                            if (step_reg + TW'(1) ==
                                (mode_reg ? pfc_pkg::MOD_STEPS : pfc_pkg::PLAIN_STEPS))
                            begin
                                last_next = 1'b1;
                            end
                        end
                    end
                    else if (pm_rd.use_bit || pm_rd.modified)
                    begin
                        // Modified clock first look: requeue and count the pass.
                        rm_we     = 1'b1;
                        pass_next = pass_reg + TW'(1);
                        if (count_reg[p_reg] < CW'(pfc_pkg::MaxResident))
                        begin
                            count_next[p_reg] = count_reg[p_reg] + CW'(1);
                        end
                        if (pass_reg + TW'(1) >= TW'(q_val))
                        begin
                            phase_next = 1'b1;
                        end
                        else
                        begin
                            step_next = step_reg + TW'(1);
                            if (step_reg + TW'(1) == pfc_pkg::MOD_STEPS)
                            begin
                                last_next = 1'b1;
                            end
                        end
                    end
                end
            end
            pfc_pkg::ST_EVICT_V:
            begin
                pm_we    = 1'b1;
                pm_waddr = v_reg;
                pm_wdata = ve_reg;
                pm_wdata.present = 1'b0;
                vv_next  = 1'b1;
                wb_next  = ve_reg.modified;
            end
            pfc_pkg::ST_EVICT_E:
            begin
                pm_we    = 1'b1;
                pm_wdata = '{owner: e_reg.owner, frame: ve_reg.frame, present: 1'b1,
                             use_bit: 1'b1, modified: 1'b0};
                rm_we    = 1'b1;
                rm_wdata = pg_reg;
                if (count_reg[p_reg] < CW'(pfc_pkg::MaxResident))
                begin
                    count_next[p_reg] = count_reg[p_reg] + CW'(1);
                end
                load_next = 1'b1;
            end
            pfc_pkg::ST_REL_RD:
            begin
                pm_raddr = rel_reg;
            end
            pfc_pkg::ST_REL_CK:
            begin
                pm_waddr = rel_reg;
                pm_wdata = pm_rd;
                pm_wdata.present = 1'b0;
                if (pm_rd.owner == pid_reg && pm_rd.present)
                begin
                    pm_we = 1'b1;
                    busy_next[pm_rd.frame] = 1'b0;
                end
                rel_next = rel_reg + PW'(1);
                if (rel_reg == PW'(pfc_pkg::NumPages - 1))
                begin
                    head_next[pid_reg]  = '0;
                    count_next[pid_reg] = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pfc_pkg::ST_IDLE;
            busy_reg  <= '0;
            fpp_reg   <= QW'(4);
            mode_reg  <= 1'b0;
            done      <= 1'b0;
            for (int i = 0; i < pfc_pkg::NumProcesses; i++)
            begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            done      <= (state_reg == pfc_pkg::ST_OUT);
            if (cfg_wr)
            begin
                if (paddr[2] == pfc_pkg::REG_FRAMES_PER_PROCESS)
                begin
                    fpp_reg <= pwdata[QW-1:0];
                end
                else
                begin
                    mode_reg <= pwdata[0];
                end
            end
        end
    end

    // Working and result registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == pfc_pkg::ST_IDLE && start)
        begin
            op_reg  <= operation;
            pg_reg  <= page;
            pid_reg <= process_id;
        end
        p_reg      <= p_next;
        e_reg      <= e_next;
        ve_reg     <= ve_next;
        v_reg      <= v_next;
        f_reg      <= f_next;
        rel_reg    <= rel_next;
        step_reg   <= step_next;
        pass_reg   <= pass_next;
        phase_reg  <= phase_next;
        last_reg   <= last_next;
        fault_reg  <= fault_next;
        load_reg   <= load_next;
        vv_reg     <= vv_next;
        wb_reg     <= wb_next;
        err_reg    <= err_next;
        if (state_reg == pfc_pkg::ST_OUT)
        begin
            present      <= pm_rd.present;
            frame        <= pm_rd.present ? pm_rd.frame : '0;
            fault        <= fault_reg;
            load_request <= load_reg;
            victim_valid <= vv_reg;
            victim_page  <= v_reg;
            writeback    <= wb_reg;
            error        <= err_reg;
        end
    end

endmodule
`default_nettype wire

[bench/page_fault_clock_replacer_unit_tb.sv]
// Self-checking testbench for page_fault_clock_replacer_unit.
// Depends on pfc_pkg and the unit. It holds its own page table model, drives
// random and directed operations and checks every result beat in order.
`default_nettype none
module page_fault_clock_replacer_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // One expected or observed result beat.
    typedef struct packed {
        logic       present;
        logic [5:0] frame;
        logic       fault;
        logic       load_request;
        logic       victim_valid;
        logic [7:0] victim_page;
        logic       writeback;
        logic       error;
    } outcome_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  operation;
    logic [7:0]  page;
    logic [1:0]  process_id;
    logic        done;
    logic        present;
    logic [5:0]  frame;
    logic        fault;
    logic        load_request;
    logic        victim_valid;
    logic [7:0]  victim_page;
    logic        writeback;
    logic        error;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    page_fault_clock_replacer_unit dut (.*);

    // Shadow state of the page table, the frame bitmap and the clock rings.
    pfc_pkg::entry_t           table_q [pfc_pkg::NumPages];
    logic                      frame_used [pfc_pkg::NumFrames];
    logic [pfc_pkg::PageW-1:0] ring_slot [pfc_pkg::NumProcesses*pfc_pkg::MaxResident];
    logic [pfc_pkg::SlotW-1:0] ring_head [pfc_pkg::NumProcesses];
    logic [pfc_pkg::CountW-1:0] ring_count [pfc_pkg::NumProcesses];
    logic [4:0]       quota_reg;
    logic             mode_reg;

    outcome_t pending_outcomes[$];
    int       mismatches;
    logic     no_gaps;
    logic [7:0] page_pool [32];

    localparam int PAGES_IN_POOL = 32;

    // Clock.
    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Ring helpers of the shadow model.
    function automatic logic [pfc_pkg::PageW-1:0] ring_take(int p);
        logic [pfc_pkg::PageW-1:0] v;
        v = ring_slot[p*pfc_pkg::MaxResident + ring_head[p]];
        ring_head[p] = ring_head[p] + 1'b1;
        if (ring_count[p] > 0)
            ring_count[p] = ring_count[p] - 1'b1;
        return v;
    endfunction

    function automatic void ring_put(int p, logic [pfc_pkg::PageW-1:0] v);
        logic [pfc_pkg::SlotW-1:0] slot;
        slot = ring_head[p] + ring_count[p][pfc_pkg::SlotW-1:0];
        ring_slot[p*pfc_pkg::MaxResident + slot] = v;
        if (ring_count[p] < pfc_pkg::MaxResident)
            ring_count[p] = ring_count[p] + 1'b1;
    endfunction

    function automatic int frame_quota();
        int q;
        q = quota_reg;
        if (q == 0)
            q = 1;
        if (q > pfc_pkg::MaxResident)
            q = pfc_pkg::MaxResident;
        return q;
    endfunction

    // Plain clock: the first page with a clear use bit goes, others get a second chance.
    function automatic logic [pfc_pkg::PageW-1:0] pick_plain(int p);
        logic [pfc_pkg::PageW-1:0] v;
        for (int s = 0; s < 2*pfc_pkg::MaxResident + 2; s++)
        begin
            v = ring_take(p);
            if (!table_q[v].use_bit)
                return v;
            table_q[v].use_bit = 1'b0;
            ring_put(p, v);
        end
        return ring_take(p);
    endfunction

    // Modified clock: clean unused pages first, later passes also clear use bits.
    function automatic logic [pfc_pkg::PageW-1:0] pick_modified(int p, int q);
        logic [pfc_pkg::PageW-1:0] v;
        int laps;
        laps = 0;
        for (int s = 0; s < 4*pfc_pkg::MaxResident + 4; s++)
        begin
            v = ring_take(p);
            if (!table_q[v].use_bit && !table_q[v].modified)
                return v;
            ring_put(p, v);
            laps++;
            if (laps >= q)
            begin
                v = ring_take(p);
                if (!table_q[v].use_bit)
                    return v;
                table_q[v].use_bit = 1'b0;
                ring_put(p, v);
            end
        end
        return ring_take(p);
    endfunction

    // Applies one operation to the shadow state and returns the result it causes.
    function automatic outcome_t apply_operation(logic [2:0] op, logic [7:0] pg,
                                                 logic [1:0] pid);
        outcome_t r;
        int p;
        int q;
        int f;
        logic [pfc_pkg::PageW-1:0] v;
        r = '0;
        case (op)
            pfc_pkg::OP_CREATE:
                if (!table_q[pg].present)
                begin
                    table_q[pg].owner = pid;
                    table_q[pg].frame = '0;
                    table_q[pg].use_bit = 1'b0;
                    table_q[pg].modified = 1'b0;
                end
            pfc_pkg::OP_TRANSLATE:
                r.fault = !table_q[pg].present;
            pfc_pkg::OP_MARK_READ:
                if (table_q[pg].present)
                    table_q[pg].use_bit = 1'b1;
            pfc_pkg::OP_MARK_WRITE:
                if (table_q[pg].present)
                begin
                    table_q[pg].use_bit = 1'b1;
                    table_q[pg].modified = 1'b1;
                end
            pfc_pkg::OP_FAULT:
                if (!table_q[pg].present)
                begin
                    p = table_q[pg].owner;
                    q = frame_quota();
                    if (ring_count[p] < q)
                    begin
                        f = 0;
                        while (f < pfc_pkg::NumFrames && frame_used[f])
                            f++;
                        if (f == pfc_pkg::NumFrames)
                            r.error = 1'b1;
                        else
                        begin
                            frame_used[f] = 1'b1;
                            table_q[pg].frame = f[pfc_pkg::FrameW-1:0];
                            table_q[pg].present = 1'b1;
                            table_q[pg].use_bit = 1'b1;
                            table_q[pg].modified = 1'b0;
                            ring_put(p, pg);
                            r.load_request = 1'b1;
                        end
                    end
                    else
                    begin
                        v = mode_reg ? pick_modified(p, q) : pick_plain(p);
                        table_q[v].present = 1'b0;
                        r.victim_valid = 1'b1;
                        r.victim_page = v;
                        r.writeback = table_q[v].modified;
                        table_q[pg].frame = table_q[v].frame;
                        table_q[pg].present = 1'b1;
                        table_q[pg].use_bit = 1'b1;
                        table_q[pg].modified = 1'b0;
                        ring_put(p, pg);
                        r.load_request = 1'b1;
                    end
                end
            pfc_pkg::OP_RELEASE:
            begin
                for (int i = 0; i < pfc_pkg::NumPages; i++)
                begin
                    if (table_q[i].owner == pid && table_q[i].present)
                    begin
                        table_q[i].present = 1'b0;
                        frame_used[table_q[i].frame] = 1'b0;
                    end
                end
                ring_head[pid] = '0;
                ring_count[pid] = '0;
            end
            default:
                ;
        endcase
        r.present = table_q[pg].present;
        r.frame = table_q[pg].present ? table_q[pg].frame : '0;
        return r;
    endfunction

    // Sends one command beat and records what it should produce.
    task automatic issue_op(logic [2:0] op, logic [7:0] pg, logic [1:0] pid);
        if (!no_gaps && $urandom_range(99) < 22)
        begin
            @(negedge clk);
            start = 1'b0;
            repeat ($urandom_range(4)) @(negedge clk);
        end
        @(negedge clk);
        start = 1'b1;
        operation = op;
        page = pg;
        process_id = pid;
        do
            @(posedge clk);
        while (busy);
        pending_outcomes.push_back(apply_operation(op, pg, pid));
    endtask

    // Lowers start and waits until every expected beat has come back.
    task automatic drain();
        @(negedge clk);
        start = 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
    endtask

    // Register write over the APB-style port; the block must be idle.
    task automatic write_register(logic regsel, logic [31:0] value);
        drain();
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {regsel, 2'b00};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (regsel == pfc_pkg::REG_FRAMES_PER_PROCESS)
            quota_reg = value[4:0];
        else
            mode_reg = value[0];
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // Result checker: every done beat is matched against the oldest expectation.
    always @(posedge clk)
    begin
        outcome_t want;
        outcome_t got;
        if (rst_n && done)
        begin
            got = '{present, frame, fault, load_request, victim_valid, victim_page,
                    writeback, error};
            if (pending_outcomes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result beat at %0t", $realtime);
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (got != want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"Mismatch at %0t: expected p=%0b f=%0d flt=%0b ld=%0b ",
                                  "vv=%0b vp=%0d wb=%0b err=%0b, got p=%0b f=%0d ",
                                  "flt=%0b ld=%0b vv=%0b vp=%0d wb=%0b err=%0b"},
                                 $realtime, want.present, want.frame, want.fault,
                                 want.load_request, want.victim_valid, want.victim_page,
                                 want.writeback, want.error, got.present, got.frame,
                                 got.fault, got.load_request, got.victim_valid,
                                 got.victim_page, got.writeback, got.error);
                end
            end
        end
    end

    // Fills the page pool with fresh random pages.
    task automatic refresh_pool();
        foreach (page_pool[i])
            page_pool[i] = 8'($urandom);
    endtask

    // Random traffic: mostly create/fault/mark lifecycles on a small page pool,
    // the rest fully random commands including unused opcodes.
    task automatic run_random(int count);
        logic [7:0] pg;
        int pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            pg = page_pool[$urandom_range(PAGES_IN_POOL - 1)];
            if (pick < 12)
                issue_op(pfc_pkg::OP_CREATE, pg, 2'($urandom));
            else if (pick < 22)
                issue_op(pfc_pkg::OP_TRANSLATE, pg, 2'($urandom));
            else if (pick < 38)
                issue_op(pfc_pkg::OP_MARK_READ, pg, 2'($urandom));
            else if (pick < 52)
                issue_op(pfc_pkg::OP_MARK_WRITE, pg, 2'($urandom));
            else if (pick < 86)
                issue_op(pfc_pkg::OP_FAULT, pg, 2'($urandom));
            else if (pick < 89)
                issue_op(pfc_pkg::OP_RELEASE, pg, 2'($urandom));
            else
                issue_op(3'($urandom), 8'($urandom), 2'($urandom));
        end
    endtask

    // Directed corners: page and field extremes, every opcode, ignored cases.
    task automatic test_directed();
        issue_op(pfc_pkg::OP_TRANSLATE, 8'd0, 2'd0);
        issue_op(pfc_pkg::OP_MARK_READ, 8'd255, 2'd3);
        issue_op(pfc_pkg::OP_MARK_WRITE, 8'd255, 2'd3);
        issue_op(pfc_pkg::OP_CREATE, 8'd0, 2'd0);
        issue_op(pfc_pkg::OP_CREATE, 8'd255, 2'd3);
        issue_op(pfc_pkg::OP_FAULT, 8'd0, 2'd0);
        issue_op(pfc_pkg::OP_FAULT, 8'd255, 2'd3);
        issue_op(pfc_pkg::OP_FAULT, 8'd255, 2'd3);
        issue_op(pfc_pkg::OP_CREATE, 8'd255, 2'd1);
        issue_op(pfc_pkg::OP_TRANSLATE, 8'd255, 2'd0);
        issue_op(pfc_pkg::OP_MARK_WRITE, 8'd0, 2'd0);
        issue_op(pfc_pkg::OP_MARK_READ, 8'd255, 2'd0);
        issue_op(3'd6, 8'd0, 2'd2);
        issue_op(3'd7, 8'd255, 2'd1);
        for (int i = 1; i <= 5; i++)
        begin
            issue_op(pfc_pkg::OP_CREATE, 8'(i * 17), 2'd0);
            issue_op(pfc_pkg::OP_FAULT, 8'(i * 17), 2'd0);
        end
        issue_op(pfc_pkg::OP_RELEASE, 8'd0, 2'd0);
        issue_op(pfc_pkg::OP_TRANSLATE, 8'd85, 2'd0);
    endtask

    // Plain clock at the reset quota, with one full drain in the middle.
    task automatic test_plain_clock();
        write_register(pfc_pkg::REG_FRAMES_PER_PROCESS, 32'd4);
        write_register(pfc_pkg::REG_REPLACEMENT_MODE, 32'd0);
        refresh_pool();
        run_random(100);
        drain();
        run_random(100);
    endtask

    // Quota register at zero acts as a single frame; then a quota of one in modified mode.
    task automatic test_min_quota();
        write_register(pfc_pkg::REG_FRAMES_PER_PROCESS, 32'd0);
        refresh_pool();
        run_random(100);
        write_register(pfc_pkg::REG_FRAMES_PER_PROCESS, 32'd1);
        write_register(pfc_pkg::REG_REPLACEMENT_MODE, 32'd1);
        run_random(100);
    endtask

    // Modified clock with the largest quota, then plain clock with a quota above the ring size.
    task automatic test_modified_clock();
        write_register(pfc_pkg::REG_FRAMES_PER_PROCESS, 32'd16);
        refresh_pool();
        run_random(150);
        write_register(pfc_pkg::REG_FRAMES_PER_PROCESS, 32'hFFFF_FFFF);
        write_register(pfc_pkg::REG_REPLACEMENT_MODE, 32'hFFFF_FFFE);
        run_random(150);
    endtask

    // Back-to-back commands with no gaps, small quota in modified mode.
    task automatic test_back_to_back();
        write_register(pfc_pkg::REG_FRAMES_PER_PROCESS, 32'd2);
        write_register(pfc_pkg::REG_REPLACEMENT_MODE, 32'd1);
        refresh_pool();
        no_gaps = 1'b1;
        run_random(200);
        no_gaps = 1'b0;
    endtask

    // Watchdog.
    initial
    begin
        #100ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Main sequence.
    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        operation = '0;
        page = '0;
        process_id = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mismatches = 0;
        no_gaps = 1'b0;
        foreach (table_q[i])
            table_q[i] = '0;
        foreach (frame_used[i])
            frame_used[i] = 1'b0;
        foreach (ring_slot[i])
            ring_slot[i] = '0;
        foreach (ring_head[i])
        begin
            ring_head[i] = '0;
            ring_count[i] = '0;
        end
        quota_reg = 5'd4;
        mode_reg = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_plain_clock();
        test_min_quota();
        test_modified_clock();
        test_back_to_back();

        drain();
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
`default_nettype wire

[files.f]
src/pfc_pkg.sv
src/page_fault_clock_replacer_unit.sv
bench/page_fault_clock_replacer_unit_tb.sv
